// ----- rtl/core/conv3x3_gray_image_macros.svh -----
// assertion helpers, clocked on clk_i and disabled during reset
`ifndef CONV3X3_GRAY_IMAGE_MACROS_SVH
`define CONV3X3_GRAY_IMAGE_MACROS_SVH

// same-cycle implication
`define C3G_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define C3G_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/c3g_pkg.sv -----
package c3g_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_COEF_BITS = 12;
  localparam int MAX_HEIGHT    = 1024;

  localparam int PIX_BITS      = 8;
  localparam int SIZE_BITS     = 11;
  localparam int POS_BITS      = 10;
  localparam int COEF_REG_BITS = 36;
  localparam int SUM_BITS      = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 36;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOT     = 3'd4
  } c3g_reg_e;

  // line store pair: a holds row r-1, b holds row r-2
  typedef struct packed {
    logic [PIX_BITS-1:0] a;
    logic [PIX_BITS-1:0] b;
  } c3g_pix_pair_t;

  // [row][col] of the 3x3 window, col 0 is the leftmost
  typedef logic [2:0][2:0][PIX_BITS-1:0] c3g_win_t;

  typedef logic [2:0][COEF_REG_BITS-1:0] c3g_coef_rows_t;

endpackage

// ----- rtl/core/c3g_line_mem.sv -----
module c3g_line_mem import c3g_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  c3g_pix_pair_t wdata_i,
  output c3g_pix_pair_t rdata_o
);

  logic [PIX_BITS-1:0] mem_a [DEPTH];
  logic [PIX_BITS-1:0] mem_b [DEPTH];
  c3g_pix_pair_t       rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_a[waddr_i] <= wdata_i.a;
      mem_b[waddr_i] <= wdata_i.b;
    end
  end

  // write-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q.a <= mem_a[raddr_i];
        rdata_q.b <= mem_b[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/c3g_mac.sv -----
module c3g_mac import c3g_pkg::*; #(
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  c3g_win_t                    win_i,
  input  c3g_coef_rows_t              coef_i,
  output logic signed [SUM_BITS-1:0]  sum_o
);

  localparam int CRW = 3 * COEF_BITS;
  localparam int PW  = COEF_BITS + PIX_BITS + 1;

  logic [2:0][CRW-1:0]        rows_ext;
  logic signed [PW-1:0]       prod [3][3];
  logic signed [SUM_BITS-1:0] row_sum [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rows_ext[k] = CRW'(coef_i[k]);
      for (int j = 0; j < 3; j++) begin
        prod[k][j] = $signed(rows_ext[k][j*COEF_BITS +: COEF_BITS])
                   * $signed({1'b0, win_i[k][j]});
      end
      row_sum[k] = SUM_BITS'(prod[k][0]) + SUM_BITS'(prod[k][1]) + SUM_BITS'(prod[k][2]);
    end
    sum_o = row_sum[0] + row_sum[1] + row_sum[2];
  end

endmodule

// ----- rtl/core/conv3x3_gray_image.sv -----
// path: the input stage registers each pixel with its line store read, and the combinational
// multiply-add feeds the result register; one pixel per cycle while out_stall_i is low,
// but a held result stalls the input; border pixels give no transaction
// reset: asynchronous, active low; clears position, window, valid flags and coefficients,
// sets width and height to 1024; line stores are not cleared, stale data reaches only border pixels
module conv3x3_gray_image import c3g_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [PIX_BITS-1:0]        pixel_in_i,
  input  logic                       frame_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SUM_BITS-1:0] filtered_value_o,
  output logic [POS_BITS-1:0]        center_row_o,
  output logic [POS_BITS-1:0]        center_col_o,
  output logic                       frame_last_o
);

  `include "conv3x3_gray_image_macros.svh"

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [SIZE_BITS-1:0]     line_width_q, frame_height_q;
  c3g_coef_rows_t           coef_q;

  logic [WW-1:0]            w_sat;
  logic [SIZE_BITS-1:0]     h_sat;

  logic [CW-1:0]            col_q, col_d, c_eff;
  logic [POS_BITS-1:0]      row_q, row_d, r_eff;
  logic [WW-1:0]            col_inc;
  logic [SIZE_BITS-1:0]     row_inc;

  logic                     in_acc;
  logic                     a_valid_q, a_valid_d, a_adv, a_prod, a_last;
  logic [PIX_BITS-1:0]      a_pix_q;
  logic [CW-1:0]            a_col_q;
  logic [POS_BITS-1:0]      a_row_q;
  c3g_pix_pair_t            rd_pair, wr_pair;

  logic [2:0][1:0][PIX_BITS-1:0] win_q, win_d;
  c3g_win_t                 mac_win;
  logic signed [SUM_BITS-1:0] mac_sum;

  logic                     out_valid_q, out_valid_d;
  logic signed [SUM_BITS-1:0] filt_q;
  logic [POS_BITS-1:0]      crow_q, ccol_q;
  logic                     last_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= SIZE_BITS'(1024);
      frame_height_q <= SIZE_BITS'(1024);
      coef_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (c3g_reg_e'(cfg_idx_i))
        REG_LINE_WIDTH:   line_width_q   <= cfg_data_i[SIZE_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[SIZE_BITS-1:0];
        REG_COEF_TOP:     coef_q[0]      <= cfg_data_i[COEF_REG_BITS-1:0];
        REG_COEF_MID:     coef_q[1]      <= cfg_data_i[COEF_REG_BITS-1:0];
        REG_COEF_BOT:     coef_q[2]      <= cfg_data_i[COEF_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width_q < SIZE_BITS'(3)) begin
      w_sat = WW'(3);
    end else if (32'(line_width_q) > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(line_width_q);
    end
    if (frame_height_q < SIZE_BITS'(3)) begin
      h_sat = SIZE_BITS'(3);
    end else if (frame_height_q > SIZE_BITS'(MAX_HEIGHT)) begin
      h_sat = SIZE_BITS'(MAX_HEIGHT);
    end else begin
      h_sat = frame_height_q;
    end
  end

  // raster position
  assign in_acc = in_valid_i && !in_stall_o;
  assign c_eff  = frame_start_i ? '0 : col_q;
  assign r_eff  = frame_start_i ? '0 : row_q;

  always_comb begin
    col_inc = WW'(c_eff) + WW'(1);
    row_inc = SIZE_BITS'(r_eff) + SIZE_BITS'(1);
    row_d   = r_eff;
    if (col_inc >= w_sat) begin
      col_d = '0;
      row_d = (row_inc >= h_sat) ? '0 : POS_BITS'(row_inc);
    end else begin
      col_d = CW'(col_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // input stage
  assign a_prod = (a_row_q >= POS_BITS'(2)) && (a_col_q >= CW'(2));
  assign a_last = ((SIZE_BITS'(a_row_q) + SIZE_BITS'(1)) == h_sat)
               && ((WW'(a_col_q) + WW'(1)) == w_sat);
  assign a_adv  = a_valid_q && (!a_prod || !out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !a_adv;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_acc) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_pix_q <= pixel_in_i;
      a_col_q <= c_eff;
      a_row_q <= r_eff;
    end
  end

  assign wr_pair.a = a_pix_q;
  assign wr_pair.b = rd_pair.a;

  c3g_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .re_i    (in_acc),
    .raddr_i (c_eff),
    .we_i    (a_adv),
    .waddr_i (a_col_q),
    .wdata_i (wr_pair),
    .rdata_o (rd_pair)
  );

  // window: [row][0] is column c-2, [row][1] is column c-1
  always_comb begin
    win_d = win_q;
    for (int k = 0; k < 3; k++) begin
      mac_win[k][0] = win_q[k][0];
      mac_win[k][1] = win_q[k][1];
    end
    mac_win[0][2] = rd_pair.b;
    mac_win[1][2] = rd_pair.a;
    mac_win[2][2] = a_pix_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k][0] = win_q[k][1];
      win_d[k][1] = mac_win[k][2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (a_adv) begin
      win_q <= win_d;
    end
  end

  c3g_mac #(
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .win_i  (mac_win),
    .coef_i (coef_q),
    .sum_o  (mac_sum)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (a_adv && a_prod) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_prod) begin
      filt_q <= mac_sum;
      crow_q <= a_row_q - POS_BITS'(1);
      ccol_q <= POS_BITS'(a_col_q - CW'(1));
      last_q <= a_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = filt_q;
  assign center_row_o     = crow_q;
  assign center_col_o     = ccol_q;
  assign frame_last_o     = last_q;

  `C3G_ASSERT_NEXT(a_frame_start_origin, in_acc && frame_start_i,
                   a_valid_q && (a_row_q == '0) && (a_col_q == '0),
                   "frame start did not restart the position")
  `C3G_ASSERT_NEXT(a_result_loaded, a_adv && a_prod,
                   out_valid_o && (center_col_o == POS_BITS'($past(a_col_q) - CW'(1))),
                   "interior pixel left no result")
  `C3G_ASSERT_NOW(a_last_position, out_valid_o && frame_last_o,
                  (center_row_o == POS_BITS'(h_sat - SIZE_BITS'(2)))
                  && (center_col_o == POS_BITS'(w_sat - WW'(2))),
                  "frame last flagged away from the last window")
  `C3G_ASSERT_NEXT(a_col_advance, in_acc && !frame_start_i && (col_inc < w_sat),
                   col_q == CW'($past(col_q) + CW'(1)),
                   "column did not advance by one")

endmodule
